// ----- hdl/bfont_pkg.sv -----
// Shared types, codes and constants for the bitmap font character generator.
package bfont_pkg;

    localparam int MAX_GLYPH_HEIGHT_DEF = 8;
    localparam int GLYPH_COUNT_DEF      = 256;

    // action codes carried on s_axis_tuser
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_PEN  = 2'd1;
    localparam logic [1:0] ACT_DRAW = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAP    = 2'd2;

    localparam logic [3:0] RST_WIDTH  = 4'd8;
    localparam logic [3:0] RST_HEIGHT = 4'd8;
    localparam logic [3:0] RST_GAP    = 4'd1;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;     // write one glyph row from the input item
        logic set_pen;  // place the pen from the input item
        logic start;    // latch the character code, reset the scan counters
        logic rd;       // read the current row
        logic rd_next;  // read the row after the current one
        logic step;     // scan one cell
        logic flush;    // release the held pixel as last, advance the pen
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;      // nothing to scan for this character
        logic cell_set;   // current cell is lit
        logic pend_valid; // a lit pixel is held back
        logic out_free;   // output register can take an item this cycle
        logic col_last;
        logic row_last;
    } t_sts;

endpackage

// ----- hdl/bfont_ctrl.sv -----
// Sequencer for load, set-pen and draw items of the character generator.
module bfont_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_action,
    output logic                 o_in_ready,
    input  bfont_pkg::t_sts      i_sts,
    output bfont_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;
    logic       step_ok;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // a lit cell with a pixel already held must hand that pixel to the output
    assign step_ok    = !(i_sts.cell_set && i_sts.pend_valid && !i_sts.out_free);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        bfont_pkg::ACT_LOAD: o_cmd.load = 1'b1;
                        bfont_pkg::ACT_PEN:  o_cmd.set_pen = 1'b1;
                        bfont_pkg::ACT_DRAW: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (i_sts.empty) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.col_last) begin
                        if (i_sts.row_last) begin
                            n_state = ST_FLUSH;
                        end else begin
                            o_cmd.rd_next = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/bfont_dp.sv -----
// Datapath: glyph memory, pen, scan counters, held pixel and output register.
module bfont_dp #(
    parameter int MAX_GLYPH_HEIGHT = bfont_pkg::MAX_GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT      = bfont_pkg::GLYPH_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfont_pkg::t_cmd   i_cmd,
    output bfont_pkg::t_sts   o_sts,
    input  logic [3:0]        i_glyph_width,
    input  logic [3:0]        i_glyph_height,
    input  logic [3:0]        i_char_gap,
    input  logic [7:0]        i_char_code,
    input  logic [2:0]        i_glyph_row,
    input  logic [7:0]        i_row_bits,
    input  logic [15:0]       i_start_x,
    input  logic [15:0]       i_start_y,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_pixel_x,
    output logic [15:0]       o_pixel_y,
    output logic              o_last
);

    localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic [7:0]        r_code;
    logic [2:0]        r_row;
    logic [2:0]        r_col;
    logic [15:0]       r_pen_x;
    logic [15:0]       r_pen_y;
    logic              r_pend_valid;
    logic [15:0]       r_pend_x;
    logic [15:0]       r_pend_y;
    logic              r_out_valid;
    logic [15:0]       r_out_x;
    logic [15:0]       r_out_y;
    logic              r_out_last;

    logic [3:0]        cols;
    logic [3:0]        rows;
    logic              code_ok;
    logic              wr_ok;
    logic [2:0]        rd_row;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              cell_set;
    logic              out_free;
    logic              out_load;
    logic [15:0]       cell_x;
    logic [15:0]       cell_y;

    // columns come from bit 7 down and never exceed a byte
    assign cols    = (i_glyph_width > 4'd8) ? 4'd8 : i_glyph_width;
    assign rows    = (i_glyph_height > 4'(MAX_GLYPH_HEIGHT)) ?
                     4'(MAX_GLYPH_HEIGHT) : i_glyph_height;
    assign code_ok = ({1'b0, r_code} < 9'(GLYPH_COUNT));
    assign wr_ok   = ({1'b0, i_char_code} < 9'(GLYPH_COUNT)) &&
                     ({1'b0, i_glyph_row} < 4'(MAX_GLYPH_HEIGHT));

    assign rd_row  = i_cmd.rd_next ? (r_row + 3'd1) : r_row;
    assign wr_addr = ADDR_W'(32'(i_char_code) * MAX_GLYPH_HEIGHT + 32'(i_glyph_row));
    assign rd_addr = ADDR_W'(32'(r_code) * MAX_GLYPH_HEIGHT + 32'(rd_row));

    assign cell_set = r_rd_data[3'd7 - r_col];
    assign cell_x   = r_pen_x + {13'd0, r_col};
    assign cell_y   = r_pen_y + {13'd0, r_row};
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = (i_cmd.step && cell_set && r_pend_valid) ||
                      (i_cmd.flush && r_pend_valid);

    assign o_sts.empty      = !code_ok || (cols == 4'd0) || (rows == 4'd0);
    assign o_sts.cell_set   = cell_set;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;
    assign o_sts.col_last   = ({1'b0, r_col} == cols - 4'd1);
    assign o_sts.row_last   = ({1'b0, r_row} == rows - 4'd1);

    // glyph memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[wr_addr] <= i_row_bits;
        end
        if (i_cmd.rd || i_cmd.rd_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_code <= i_char_code;
            r_row  <= 3'd0;
            r_col  <= 3'd0;
        end else if (i_cmd.step) begin
            if (o_sts.col_last) begin
                r_col <= 3'd0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
        if (i_cmd.step && cell_set) begin
            r_pend_x <= cell_x;
            r_pend_y <= cell_y;
        end
        if (out_load) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.set_pen) begin
                r_pen_x <= i_start_x;
                r_pen_y <= i_start_y;
            end else if (i_cmd.flush) begin
                r_pen_x <= r_pen_x + 16'(i_glyph_width) + 16'(i_char_gap);
            end

            if (i_cmd.start || i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && cell_set) begin
                r_pend_valid <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_last      = r_out_last;

endmodule

// ----- hdl/bitmap_font_text_renderer.sv -----
// Top level of the bitmap font character generator: ports, registers, wiring.
// Ready stays high across load and set-pen items.
// A draw runs a read-setup step, one glyph cell per cycle unless output back-pressure
// stalls the scan, and a finish step. A lit pixel waits for the next lit cell or the finish.
// Sync active-low reset clears pen, config, control; glyph memory is garbage until written.
module bitmap_font_text_renderer #(
    parameter int MAX_GLYPH_HEIGHT = bfont_pkg::MAX_GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT      = bfont_pkg::GLYPH_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_code[7:0], glyph_row[10:8], row_bits[18:11], start_x[34:19],
    // start_y[50:35], zero pad[55:51]
    input  logic [bfont_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action[1:0]
    input  logic [bfont_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_x[15:0], pixel_y[31:16]
    output logic [bfont_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfont_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bfont_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bfont_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    bfont_pkg::t_cmd cmd;
    bfont_pkg::t_sts sts;

    logic [3:0]  r_glyph_width;
    logic [3:0]  r_glyph_height;
    logic [3:0]  r_char_gap;
    logic [1:0]  reg_idx;
    logic        cfg_wr;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;

    // --- configuration registers, one word apart ---
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= bfont_pkg::RST_WIDTH;
            r_glyph_height <= bfont_pkg::RST_HEIGHT;
            r_char_gap     <= bfont_pkg::RST_GAP;
        end else if (cfg_wr) begin
            case (reg_idx)
                bfont_pkg::REG_WIDTH:  r_glyph_width  <= pwdata[3:0];
                bfont_pkg::REG_HEIGHT: r_glyph_height <= pwdata[3:0];
                bfont_pkg::REG_GAP:    r_char_gap     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bfont_pkg::REG_WIDTH:  prdata = {28'd0, r_glyph_width};
            bfont_pkg::REG_HEIGHT: prdata = {28'd0, r_glyph_height};
            bfont_pkg::REG_GAP:    prdata = {28'd0, r_char_gap};
            default:               prdata = '0;
        endcase
    end

    // --- sequencer: accepts items only when no draw is in progress ---
    bfont_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser[1:0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // --- datapath: each lit pixel is held until the next lit cell or the finish so the last can be marked ---
    bfont_dp #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .GLYPH_COUNT      (GLYPH_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_glyph_width  (r_glyph_width),
        .i_glyph_height (r_glyph_height),
        .i_char_gap     (r_char_gap),
        .i_char_code    (s_axis_tdata[7:0]),
        .i_glyph_row    (s_axis_tdata[10:8]),
        .i_row_bits     (s_axis_tdata[18:11]),
        .i_start_x      (s_axis_tdata[34:19]),
        .i_start_y      (s_axis_tdata[50:35]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_y, pixel_x};

endmodule

// ----- hdl/bfont_chk.sv -----
// Port-level checks for the bitmap font character generator, bound to the top.
module bfont_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [bfont_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input logic [bfont_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [bfont_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                                m_axis_tlast,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [bfont_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [bfont_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [bfont_pkg::APB_DATA_W-1:0]    prdata,
    input logic                                pready
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a draw keeps the input side busy on the following cycle
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == bfont_pkg::ACT_DRAW)
            |=> !s_axis_tready)
        else $error("input ready right after a draw item");

    // load and set-pen items never produce a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != bfont_pkg::ACT_DRAW)
            && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result from a non-draw item");

endmodule

bind bitmap_font_text_renderer bfont_chk u_bfont_chk (.*);
